### rtl/core/affine_transform_inverse_defines.svh
// assertion macros for the affine transform inverse block
// used by the rtl files under rtl/core that carry assertions
`ifndef AFFINE_TRANSFORM_INVERSE_DEFINES_SVH
`define AFFINE_TRANSFORM_INVERSE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define ATI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ATI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ATI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ATI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/ati_pkg.sv
// shared types, constants and helpers of the affine transform inverse
// no dependencies
package ati_pkg;

    localparam int WORD_W        = 32;
    localparam int ITEM_N        = 12;
    localparam int ITEM_W        = ITEM_N * WORD_W;
    localparam int ACC_W         = 99;
    localparam int COF_W         = 65;
    localparam int FRAC_BITS_DEF = 16;
    localparam int Q_DEPTH_DEF   = 2;

    localparam logic [WORD_W-1:0] THR_RESET = 32'd42950;
    localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7fff_ffff;

    typedef logic [ITEM_N-1:0][WORD_W-1:0] t_item;

    // cofactor j = m[A[2j]]*m[B[2j]] - m[A[2j+1]]*m[B[2j+1]]
    localparam logic [3:0] COF_A [18] = '{
        4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
        4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
    localparam logic [3:0] COF_B [18] = '{
        4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
        4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};

    // sign and magnitude to a saturated 32-bit word
    function automatic logic [WORD_W-1:0] sat_word(input logic neg,
                                                   input logic [ACC_W-1:0] mag);
        logic big;
        big = (|mag[ACC_W-1:WORD_W]) | mag[WORD_W-1];
        if (neg) begin
            sat_word = big ? WORD_MIN : (~mag[WORD_W-1:0] + 1'b1);
        end else begin
            sat_word = big ? WORD_MAX : mag[WORD_W-1:0];
        end
    endfunction

endpackage

### rtl/core/ati_fifo.sv
// small register queue, used for the input and result sides
// depends on nothing but its parameters
module ati_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_mem[r_wp] <= i_wdata;
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

### rtl/core/ati_engine.sv
// back part: cofactors, determinant, bit-serial divide and translation
// depends on ati_pkg and the assertion macro header
`include "affine_transform_inverse_defines.svh"
module ati_engine #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ati_pkg::WORD_W-1:0] i_cfg_wdata,
    input  logic                       i_in_empty,
    input  ati_pkg::t_item             i_in_data,
    output logic                       o_in_pop,
    input  logic                       i_out_full,
    output ati_pkg::t_item             o_out_data,
    output logic                       o_out_push
);
    import ati_pkg::*;

    localparam int DW = ACC_W;
    localparam int CW = COF_W;
    localparam int RW = (66 + 2 * FRAC_BITS > 134) ? 66 + 2 * FRAC_BITS : 134;

    typedef enum logic [3:0] {
        S_IDLE, S_COF, S_DET, S_CHK, S_DSET, S_DIV, S_DFIN, S_TR, S_TRND, S_OUT
    } t_state;

    t_state                   r_state;
    logic [4:0]               r_k;
    logic                     r_ph;
    logic [3:0]               r_i;
    logic [5:0]               r_bit;
    logic [WORD_W-1:0]        r_thr;
    logic signed [WORD_W-1:0] r_m [9];
    logic signed [WORD_W-1:0] r_t [3];
    logic signed [CW-1:0]     r_c [9];
    logic signed [WORD_W-1:0] r_b [9];
    logic [WORD_W-1:0]        r_u [3];
    logic signed [65:0]       r_prod;
    logic signed [DW-1:0]     r_acc;
    logic [DW-1:0]            r_adet;
    logic                     r_det_neg;
    logic [RW-1:0]            r_rem;
    logic [RW-1:0]            r_dsh;
    logic [32:0]              r_q;

    logic signed [32:0]   mul_a;
    logic signed [32:0]   mul_b;
    logic signed [DW-1:0] prod_ext;
    logic signed [DW-1:0] prod_sh;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        acc_abs;
    logic [DW-1:0]        lim;
    logic [DW-1:0]        rmag;
    logic signed [CW-1:0] c_sel;
    logic signed [CW-1:0] c_abs;
    logic [RW-1:0]        num;
    logic                 ovf;
    logic                 q_sign;
    logic [1:0]           dj;
    logic [3:0]           cidx;
    logic [3:0]           bidx;

    assign prod_ext = {{(DW - 66){r_prod[65]}}, r_prod};
    assign prod_sh  = {{(DW - 98){r_prod[65]}}, r_prod, 32'b0};
    assign diff     = r_acc - prod_ext;
    assign acc_abs  = r_acc[DW-1] ? DW'(-r_acc) : DW'(r_acc);
    assign lim      = DW'(r_thr) << FRAC_BITS;
    assign rmag     = (acc_abs + (DW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign c_sel    = r_c[r_i];
    assign c_abs    = c_sel[CW-1] ? -c_sel : c_sel;
    assign num      = (RW'(c_abs[CW-2:0]) << (2 * FRAC_BITS + 1)) + RW'(r_adet);
    assign ovf      = (num >= (RW'(r_adet) << 34));
    assign q_sign   = c_sel[CW-1] ^ r_det_neg;
    assign dj       = r_k[2:1];
    assign cidx     = {dj, 1'b0} + 4'(dj);
    assign bidx     = r_i + {1'b0, r_k[1:0], 1'b0} + 4'(r_k[1:0]);

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_COF: begin
                mul_a = {r_m[COF_A[r_k]][WORD_W-1], r_m[COF_A[r_k]]};
                mul_b = {r_m[COF_B[r_k]][WORD_W-1], r_m[COF_B[r_k]]};
            end
            S_DET: begin
                mul_a = {r_m[4'(dj)][WORD_W-1], r_m[4'(dj)]};
                mul_b = r_k[0] ? r_c[cidx][CW-1:32] : {1'b0, r_c[cidx][31:0]};
            end
            S_TR: begin
                mul_a = {r_b[bidx][WORD_W-1], r_b[bidx]};
                mul_b = {r_t[r_k[1:0]][WORD_W-1], r_t[r_k[1:0]]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign o_in_pop   = (r_state == S_IDLE) && !i_in_empty;
    assign o_out_push = (r_state == S_OUT) && !i_out_full;

    always_comb begin
        for (int n = 0; n < 9; n++) begin
            o_out_data[n] = r_b[n];
        end
        for (int n = 0; n < 3; n++) begin
            o_out_data[9 + n] = r_u[n];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_ph    <= 1'b0;
            r_i     <= '0;
            r_bit   <= '0;
            r_thr   <= THR_RESET;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            r_prod <= mul_a * mul_b;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_in_empty) begin
                        for (int n = 0; n < 9; n++) begin
                            r_m[n] <= i_in_data[n];
                        end
                        for (int n = 0; n < 3; n++) begin
                            r_t[n] <= i_in_data[9 + n];
                        end
                        r_k     <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_COF;
                    end
                end
                S_COF: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (!r_k[0]) begin
                            r_acc <= prod_ext;
                        end else begin
                            r_c[r_k[4:1]] <= diff[CW-1:0];
                        end
                        if (r_k == 5'd17) begin
                            r_k     <= '0;
                            r_acc   <= '0;
                            r_state <= S_DET;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_DET: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_acc <= r_acc + (r_k[0] ? prod_sh : prod_ext);
                        if (r_k == 5'd5) begin
                            r_k     <= '0;
                            r_state <= S_CHK;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_CHK: begin
                    r_adet    <= acc_abs;
                    r_det_neg <= r_acc[DW-1];
                    r_i       <= '0;
                    r_k       <= '0;
                    r_ph      <= 1'b0;
                    if (acc_abs <= lim) begin
                        // near singular: identity
                        for (int n = 0; n < 9; n++) begin
                            r_b[n] <= (n == 0 || n == 4 || n == 8) ?
                                      (WORD_W'(1) << FRAC_BITS) : '0;
                        end
                        r_state <= S_TR;
                    end else begin
                        r_state <= S_DSET;
                    end
                end
                S_DSET: begin
                    if (ovf) begin
                        r_b[r_i] <= q_sign ? WORD_MIN : WORD_MAX;
                        if (r_i == 4'd8) begin
                            r_i     <= '0;
                            r_state <= S_TR;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_rem   <= num;
                        r_dsh   <= RW'(r_adet) << 33;
                        r_bit   <= 6'd32;
                        r_q     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_rem >= r_dsh) begin
                        r_rem      <= r_rem - r_dsh;
                        r_q[r_bit] <= 1'b1;
                    end
                    r_dsh <= r_dsh >> 1;
                    if (r_bit == '0) begin
                        r_state <= S_DFIN;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_DFIN: begin
                    r_b[r_i] <= sat_word(q_sign && (r_q != '0), DW'(r_q));
                    if (r_i == 4'd8) begin
                        r_i     <= '0;
                        r_state <= S_TR;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_DSET;
                    end
                end
                S_TR: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_acc <= ((r_k == '0) ? '0 : r_acc) + prod_ext;
                        if (r_k == 5'd2) begin
                            r_k     <= '0;
                            r_state <= S_TRND;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_TRND: begin
                    // negated, rounded half away from zero
                    r_u[r_i[1:0]] <= sat_word(!r_acc[DW-1] && (rmag != '0), rmag);
                    if (r_i == 4'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_TR;
                    end
                end
                S_OUT: begin
                    if (!i_out_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ATI_ASSERT_IMP(a_rem_bound, i_clk, i_rst_n, r_state == S_DIV, r_rem < (r_dsh << 1))
    `ATI_ASSERT_NXT(a_pop_start, i_clk, i_rst_n, o_in_pop, r_state == S_COF)
    `ATI_ASSERT_IMP(a_elem_range, i_clk, i_rst_n, r_state == S_DSET || r_state == S_DFIN, r_i <= 4'd8)

endmodule

### rtl/core/affine_transform_inverse.sv
// affine transform inverse: from accept to result a regular matrix passes take, cofactor,
// determinant, check, a divide for each of the nine elements, translation and hand-on; an
// element whose quotient saturates at once skips its divide, and all divides are skipped
// when the determinant is at or below the threshold; one item per back-end pass, the next
// taken once the last is handed on, which waits while the result queue is full; the shared
// divider steps one quotient bit a cycle; reset empties both queues, threshold 42950
module affine_transform_inverse #(
    parameter int FRAC_BITS = ati_pkg::FRAC_BITS_DEF,
    parameter int Q_DEPTH   = ati_pkg::Q_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input side
    input  logic                              push,
    output logic                              full,
    input  logic signed [ati_pkg::WORD_W-1:0] i_a00,
    input  logic signed [ati_pkg::WORD_W-1:0] i_a10,
    input  logic signed [ati_pkg::WORD_W-1:0] i_a20,
    input  logic signed [ati_pkg::WORD_W-1:0] i_a01,
    input  logic signed [ati_pkg::WORD_W-1:0] i_a11,
    input  logic signed [ati_pkg::WORD_W-1:0] i_a21,
    input  logic signed [ati_pkg::WORD_W-1:0] i_a02,
    input  logic signed [ati_pkg::WORD_W-1:0] i_a12,
    input  logic signed [ati_pkg::WORD_W-1:0] i_a22,
    input  logic signed [ati_pkg::WORD_W-1:0] i_tx,
    input  logic signed [ati_pkg::WORD_W-1:0] i_ty,
    input  logic signed [ati_pkg::WORD_W-1:0] i_tz,
    // threshold register
    input  logic                              i_cfg_we,
    input  logic        [ati_pkg::WORD_W-1:0] i_cfg_wdata,
    // result side
    output logic                              empty,
    input  logic                              pop,
    output logic signed [ati_pkg::WORD_W-1:0] o_b00,
    output logic signed [ati_pkg::WORD_W-1:0] o_b10,
    output logic signed [ati_pkg::WORD_W-1:0] o_b20,
    output logic signed [ati_pkg::WORD_W-1:0] o_b01,
    output logic signed [ati_pkg::WORD_W-1:0] o_b11,
    output logic signed [ati_pkg::WORD_W-1:0] o_b21,
    output logic signed [ati_pkg::WORD_W-1:0] o_b02,
    output logic signed [ati_pkg::WORD_W-1:0] o_b12,
    output logic signed [ati_pkg::WORD_W-1:0] o_b22,
    output logic signed [ati_pkg::WORD_W-1:0] o_ux,
    output logic signed [ati_pkg::WORD_W-1:0] o_uy,
    output logic signed [ati_pkg::WORD_W-1:0] o_uz
);
    import ati_pkg::*;

    t_item in_item;
    t_item in_head;
    t_item out_item;
    t_item out_head;
    logic  in_empty;
    logic  in_pop;
    logic  out_full;
    logic  out_push;

    // item layout: linear part column by column, then the translation
    assign in_item[0]  = i_a00;
    assign in_item[1]  = i_a10;
    assign in_item[2]  = i_a20;
    assign in_item[3]  = i_a01;
    assign in_item[4]  = i_a11;
    assign in_item[5]  = i_a21;
    assign in_item[6]  = i_a02;
    assign in_item[7]  = i_a12;
    assign in_item[8]  = i_a22;
    assign in_item[9]  = i_tx;
    assign in_item[10] = i_ty;
    assign in_item[11] = i_tz;

    // front: accept queue, decouples the caller from the engine
    ati_fifo #(
        .W     (ITEM_W),
        .DEPTH (Q_DEPTH)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (in_item),
        .o_full  (full),
        .i_pop   (in_pop),
        .o_rdata (in_head),
        .o_empty (in_empty)
    );

    // back: sequenced arithmetic on one item at a time
    ati_engine #(
        .FRAC_BITS (FRAC_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_empty  (in_empty),
        .i_in_data   (in_head),
        .o_in_pop    (in_pop),
        .i_out_full  (out_full),
        .o_out_data  (out_item),
        .o_out_push  (out_push)
    );

    // result queue, lets the engine finish while the consumer stalls
    ati_fifo #(
        .W     (ITEM_W),
        .DEPTH (Q_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (out_item),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (out_head),
        .o_empty (empty)
    );

    assign o_b00 = out_head[0];
    assign o_b10 = out_head[1];
    assign o_b20 = out_head[2];
    assign o_b01 = out_head[3];
    assign o_b11 = out_head[4];
    assign o_b21 = out_head[5];
    assign o_b02 = out_head[6];
    assign o_b12 = out_head[7];
    assign o_b22 = out_head[8];
    assign o_ux  = out_head[9];
    assign o_uy  = out_head[10];
    assign o_uz  = out_head[11];

endmodule
